// File: design/fqs_pkg.sv
// Package with the shared types and constants of the searchable FIFO queue.
package fqs_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned OCC_W   = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQUEUE = 2'd0,
        KIND_DEQUEUE = 2'd1,
        KIND_SEARCH  = 2'd2,
        KIND_NOP     = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQUEUE,
        S_SEARCH
    } t_state;

endpackage

// File: design/fifo_queue_with_search.sv
// Top level of the bounded FIFO queue of signed values with linear search.
//
// One command channel and one result channel. A command (i_kind, i_value)
// is taken at a rising edge where start is high and busy is low. Every
// command yields exactly one result, shown for one cycle with o_valid high;
// the receiver cannot hold results off, so it must take them as they come.
// Enqueue, refused enqueue, empty dequeue, empty search and the unused kind
// give their result in the cycle after the transfer and busy stays low, so
// such commands can follow every cycle. A dequeue first reads the head
// entry through the synchronous read port of the entry memory and then, in
// state S_DEQUEUE, passes it to the result registers. A search reads one
// stored entry per cycle from the head onward through the single read port
// of the entry memory and ends at the first match or after the last stored
// entry. While busy is high no command is taken. Reset empties the queue
// (head and count clear) and drops any command in progress; the entry memory
// is not cleared, and only entries that have been written are ever used.
module fifo_queue_with_search #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [fqs_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [fqs_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_valid,
    output logic [fqs_pkg::STAT_W-1:0]          o_status,
    output logic signed [fqs_pkg::VALUE_W-1:0]  o_data,
    output logic [fqs_pkg::POS_W-1:0]           o_position,
    output logic [fqs_pkg::OCC_W-1:0]           o_occupancy
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [fqs_pkg::VALUE_W-1:0] mem [DEPTH];

    fqs_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx, n_idx;
    logic [fqs_pkg::VALUE_W-1:0] r_key, n_key;
    logic [fqs_pkg::VALUE_W-1:0] r_rd_data;

    logic                        r_valid, n_valid;
    logic [fqs_pkg::STAT_W-1:0]  r_status, n_status;
    logic [fqs_pkg::VALUE_W-1:0] r_data, n_data;
    logic [fqs_pkg::POS_W-1:0]   r_position, n_position;
    logic [fqs_pkg::OCC_W-1:0]   r_occupancy, n_occupancy;

    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [AW:0]   idx_next;
    logic          full;
    logic          empty;
    logic          hit;
    logic          last;
    logic [31:0]   pos_wide;
    logic [31:0]   occ_wide;
    logic [AW-1:0] res_pos;
    logic [CW-1:0] res_occ;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] x);
        logic [AW:0] lim;
        lim = (AW+1)'(DEPTH);
        if (x >= lim) begin
            return AW'(x - lim);
        end
        return AW'(x);
    endfunction

    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);
    assign idx_next = (AW+1)'(r_idx) + (AW+1)'(1);
    assign hit      = (r_rd_data == r_key);
    assign last     = (idx_next == (AW+1)'(r_count));
    assign wr_addr  = wrap((AW+1)'(r_head) + (AW+1)'(r_count));
    assign pos_wide = 32'(res_pos);
    assign occ_wide = 32'(res_occ);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_key       = r_key;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_data      = r_data;
        n_position  = r_position;
        n_occupancy = r_occupancy;
        mem_we      = 1'b0;
        rd_addr     = r_head;
        res_pos     = '0;
        res_occ     = r_count;
        unique case (r_state)
            fqs_pkg::S_IDLE: begin
                if (start) begin
                    n_valid  = 1'b1;
                    n_status = fqs_pkg::STAT_OK;
                    n_data   = '0;
                    n_idx    = '0;
                    n_key    = i_value;
                    unique case (fqs_pkg::t_kind'(i_kind))
                        fqs_pkg::KIND_ENQUEUE: begin
                            if (full) begin
                                n_status = fqs_pkg::STAT_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                                res_occ = n_count;
                            end
                        end
                        fqs_pkg::KIND_DEQUEUE: begin
                            if (empty) begin
                                n_status = fqs_pkg::STAT_EMPTY;
                            end else begin
                                n_valid = 1'b0;
                                n_state = fqs_pkg::S_DEQUEUE;
                            end
                        end
                        fqs_pkg::KIND_SEARCH: begin
                            if (empty) begin
                                n_status = fqs_pkg::STAT_NOT_FOUND;
                            end else begin
                                n_valid = 1'b0;
                                n_state = fqs_pkg::S_SEARCH;
                            end
                        end
                        fqs_pkg::KIND_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            fqs_pkg::S_DEQUEUE: begin
                n_valid  = 1'b1;
                n_status = fqs_pkg::STAT_OK;
                n_data   = r_rd_data;
                n_head   = wrap((AW+1)'(r_head) + (AW+1)'(1));
                n_count  = r_count - CW'(1);
                res_occ  = n_count;
                n_state  = fqs_pkg::S_IDLE;
            end
            fqs_pkg::S_SEARCH: begin
                rd_addr = wrap((AW+1)'(r_head) + idx_next);
                if (hit) begin
                    n_valid  = 1'b1;
                    n_status = fqs_pkg::STAT_OK;
                    res_pos  = r_idx;
                    n_state  = fqs_pkg::S_IDLE;
                end else if (last) begin
                    n_valid  = 1'b1;
                    n_status = fqs_pkg::STAT_NOT_FOUND;
                    n_state  = fqs_pkg::S_IDLE;
                end else begin
                    n_idx = AW'(idx_next);
                end
            end
            default: begin
                n_state = fqs_pkg::S_IDLE;
            end
        endcase
        if (n_valid) begin
            n_position  = pos_wide[fqs_pkg::POS_W-1:0];
            n_occupancy = occ_wide[fqs_pkg::OCC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= i_value;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fqs_pkg::S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_key       <= n_key;
        r_status    <= n_status;
        r_data      <= n_data;
        r_position  <= n_position;
        r_occupancy <= n_occupancy;
    end

    assign busy        = (r_state != fqs_pkg::S_IDLE);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_data      = r_data;
    assign o_position  = r_position;
    assign o_occupancy = r_occupancy;

endmodule

// File: design/fqs_checker.sv
// Port-level checker for the searchable FIFO queue and its bind statement.
module fqs_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_valid,
    input logic [fqs_pkg::STAT_W-1:0]          o_status,
    input logic signed [fqs_pkg::VALUE_W-1:0]  o_data,
    input logic [fqs_pkg::POS_W-1:0]           o_position,
    input logic [fqs_pkg::OCC_W-1:0]           o_occupancy
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_valid)
        else $error("Block is busy or shows a result right after reset.");

    a_transfer_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> o_valid || busy)
        else $error("A command transfer neither produced a result nor raised busy.");

    a_busy_ends_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_valid)
        else $error("Busy dropped without delivering a result.");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == fqs_pkg::STAT_EMPTY |-> o_occupancy == '0 && o_data == '0)
        else $error("An empty-queue result reports entries or data.");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == fqs_pkg::STAT_FULL |-> o_data == '0 && o_position == '0)
        else $error("A refused enqueue reports data or a position.");

endmodule

bind fifo_queue_with_search fqs_checker u_fqs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_status    (o_status),
    .o_data      (o_data),
    .o_position  (o_position),
    .o_occupancy (o_occupancy)
);

// File: bench/fifo_queue_with_search_tb.sv
// Self-checking testbench for the searchable FIFO queue with a built-in queue predictor.
module fifo_queue_with_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int STALL_LIMIT = 500;
    localparam int RAND_ITEMS  = 400;

    typedef struct packed {
        fqs_pkg::t_status            status;
        logic [fqs_pkg::VALUE_W-1:0] data;
        logic [fqs_pkg::POS_W-1:0]   position;
        logic [fqs_pkg::OCC_W-1:0]   occupancy;
    } t_queue_res;

    typedef struct packed {
        fqs_pkg::t_kind              kind;
        logic [fqs_pkg::VALUE_W-1:0] value;
        logic [4:0]                  reps;
        logic                        typed;
        t_queue_res                  want;
    } t_stim_row;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic [fqs_pkg::KIND_W-1:0]         i_kind;
    logic signed [fqs_pkg::VALUE_W-1:0] i_value;
    logic                               o_valid;
    logic [fqs_pkg::STAT_W-1:0]         o_status;
    logic signed [fqs_pkg::VALUE_W-1:0] o_data;
    logic [fqs_pkg::POS_W-1:0]          o_position;
    logic [fqs_pkg::OCC_W-1:0]          o_occupancy;

    logic [fqs_pkg::VALUE_W-1:0] model_mem [DEPTH];
    int                          model_head;
    int                          model_count;

    t_queue_res results_due[$];
    t_queue_res due;
    t_queue_res predicted;
    t_stim_row  stim_rows[$];
    logic       typed_flag;
    t_queue_res typed_want;
    int         mismatches;
    int         stall_cycles;
    int         calm_left;

    fifo_queue_with_search #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_kind(i_kind),
        .i_value(i_value),
        .o_valid(o_valid),
        .o_status(o_status),
        .o_data(o_data),
        .o_position(o_position),
        .o_occupancy(o_occupancy)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [SLOT_W-1:0] slot(input int k);
        return SLOT_W'(k % DEPTH);
    endfunction

    function automatic t_queue_res queue_apply(fqs_pkg::t_kind kind,
                                               logic [fqs_pkg::VALUE_W-1:0] value);
        t_queue_res res;
        bit         found;
        int         i;
        res.status    = fqs_pkg::STAT_OK;
        res.data      = '0;
        res.position  = '0;
        res.occupancy = '0;
        found         = 1'b0;
        case (kind)
            fqs_pkg::KIND_ENQUEUE: begin
                if (model_count >= DEPTH) begin
                    res.status = fqs_pkg::STAT_FULL;
                end else begin
                    model_mem[slot(model_head + model_count)] = value;
                    model_count++;
                end
            end
            fqs_pkg::KIND_DEQUEUE: begin
                if (model_count == 0) begin
                    res.status = fqs_pkg::STAT_EMPTY;
                end else begin
                    res.data   = model_mem[slot(model_head)];
                    model_head = (model_head + 1) % DEPTH;
                    model_count--;
                end
            end
            fqs_pkg::KIND_SEARCH: begin
                for (i = 0; i < model_count && !found; i++) begin
                    if (model_mem[slot(model_head + i)] == value) begin
                        found        = 1'b1;
                        res.position = i[fqs_pkg::POS_W-1:0];
                    end
                end
                if (!found) begin
                    res.status = fqs_pkg::STAT_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
        res.occupancy = model_count[fqs_pkg::OCC_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (results_due.size() == 0) begin
                report_mismatch("unrequested result", 32'(o_status), '0);
            end else begin
                due = results_due.pop_front();
                if (o_status !== due.status) begin
                    report_mismatch("status", 32'(o_status), 32'(due.status));
                end
                if (o_data !== due.data) begin
                    report_mismatch("data", o_data, due.data);
                end
                if (o_position !== due.position) begin
                    report_mismatch("position", 32'(o_position), 32'(due.position));
                end
                if (o_occupancy !== due.occupancy) begin
                    report_mismatch("occupancy", 32'(o_occupancy), 32'(due.occupancy));
                end
            end
        end
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
            predicted = queue_apply(fqs_pkg::t_kind'(i_kind), i_value);
            results_due.push_back(typed_flag ? typed_want : predicted);
            stall_cycles = 0;
        end else if (o_valid === 1'b1) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        roll = int'($urandom_range(0, 99));
        if (roll < 3) begin
            calm_left = int'($urandom_range(10, 40));
        end
        if (roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(8, 40));
    endfunction

    function automatic logic [fqs_pkg::VALUE_W-1:0] pick_value();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roll < 8) begin
            return 32'h8000_0000;
        end
        if (roll < 16) begin
            return 32'h7fff_ffff;
        end
        if (roll < 22) begin
            return 32'hffff_ffff;
        end
        if (roll < 28) begin
            return '0;
        end
        if (roll < 45) begin
            return $urandom_range(0, 7);
        end
        return $urandom;
    endfunction

    function automatic t_stim_row make_row(fqs_pkg::t_kind kind,
                                           logic [fqs_pkg::VALUE_W-1:0] value, int reps,
                                           bit typed, fqs_pkg::t_status status,
                                           logic [fqs_pkg::VALUE_W-1:0] data,
                                           int position, int occupancy);
        t_stim_row row;
        row.kind           = kind;
        row.value          = value;
        row.reps           = reps[4:0];
        row.typed          = typed;
        row.want.status    = status;
        row.want.data      = data;
        row.want.position  = position[fqs_pkg::POS_W-1:0];
        row.want.occupancy = occupancy[fqs_pkg::OCC_W-1:0];
        return row;
    endfunction

    // The task returns on a falling edge; start stays high only when the next
    // command follows without a gap.
    task automatic send_request(input fqs_pkg::t_kind kind,
                                input logic [fqs_pkg::VALUE_W-1:0] value,
                                input bit typed, input t_queue_res want);
        int gap;
        i_kind     <= kind;
        i_value    <= value;
        start      <= 1'b1;
        typed_flag = typed;
        typed_want = want;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    initial begin
        t_stim_row      row;
        t_queue_res     none;
        fqs_pkg::t_kind kind;
        logic [31:0]    value;
        bit             filling;
        int             roll;
        int             n;
        int             r;

        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_kind       = fqs_pkg::KIND_NOP;
        i_value      = '0;
        typed_flag   = 1'b0;
        typed_want   = '0;
        none         = '0;
        mismatches   = 0;
        stall_cycles = 0;
        calm_left    = 0;
        model_head   = 0;
        model_count  = 0;
        filling      = 1'b1;

        stim_rows.push_back(make_row(fqs_pkg::KIND_DEQUEUE, 32'h0, 1, 1,
                                     fqs_pkg::STAT_EMPTY, 0, 0, 0));
        stim_rows.push_back(make_row(fqs_pkg::KIND_SEARCH, 32'h0, 1, 1,
                                     fqs_pkg::STAT_NOT_FOUND, 0, 0, 0));
        stim_rows.push_back(make_row(fqs_pkg::KIND_NOP, 32'h7fff_ffff, 1, 1,
                                     fqs_pkg::STAT_OK, 0, 0, 0));
        stim_rows.push_back(make_row(fqs_pkg::KIND_ENQUEUE, 32'h8000_0000, 1, 1,
                                     fqs_pkg::STAT_OK, 0, 0, 1));
        stim_rows.push_back(make_row(fqs_pkg::KIND_ENQUEUE, 32'h7fff_ffff, 1, 1,
                                     fqs_pkg::STAT_OK, 0, 0, 2));
        stim_rows.push_back(make_row(fqs_pkg::KIND_ENQUEUE, 32'hffff_ffff, 1, 1,
                                     fqs_pkg::STAT_OK, 0, 0, 3));
        stim_rows.push_back(make_row(fqs_pkg::KIND_ENQUEUE, 32'h7fff_ffff, 1, 1,
                                     fqs_pkg::STAT_OK, 0, 0, 4));
        stim_rows.push_back(make_row(fqs_pkg::KIND_SEARCH, 32'h7fff_ffff, 1, 1,
                                     fqs_pkg::STAT_OK, 0, 1, 4));
        stim_rows.push_back(make_row(fqs_pkg::KIND_SEARCH, 32'hffff_ffff, 1, 1,
                                     fqs_pkg::STAT_OK, 0, 2, 4));
        stim_rows.push_back(make_row(fqs_pkg::KIND_SEARCH, 32'h0, 1, 1,
                                     fqs_pkg::STAT_NOT_FOUND, 0, 0, 4));
        stim_rows.push_back(make_row(fqs_pkg::KIND_ENQUEUE, 32'h100, 12, 0,
                                     fqs_pkg::STAT_OK, 0, 0, 0));
        stim_rows.push_back(make_row(fqs_pkg::KIND_ENQUEUE, 32'h0, 1, 1,
                                     fqs_pkg::STAT_FULL, 0, 0, 16));
        stim_rows.push_back(make_row(fqs_pkg::KIND_SEARCH, 32'h10b, 1, 1,
                                     fqs_pkg::STAT_OK, 0, 15, 16));
        stim_rows.push_back(make_row(fqs_pkg::KIND_NOP, 32'hffff_ffff, 1, 1,
                                     fqs_pkg::STAT_OK, 0, 0, 16));
        stim_rows.push_back(make_row(fqs_pkg::KIND_DEQUEUE, 32'h0, 1, 1,
                                     fqs_pkg::STAT_OK, 32'h8000_0000, 0, 15));
        stim_rows.push_back(make_row(fqs_pkg::KIND_DEQUEUE, 32'h0, 1, 1,
                                     fqs_pkg::STAT_OK, 32'h7fff_ffff, 0, 14));
        stim_rows.push_back(make_row(fqs_pkg::KIND_ENQUEUE, 32'h5555_aaaa, 1, 0,
                                     fqs_pkg::STAT_OK, 0, 0, 0));
        stim_rows.push_back(make_row(fqs_pkg::KIND_SEARCH, 32'h7fff_ffff, 1, 0,
                                     fqs_pkg::STAT_OK, 0, 0, 0));
        stim_rows.push_back(make_row(fqs_pkg::KIND_DEQUEUE, 32'h0, 16, 0,
                                     fqs_pkg::STAT_OK, 0, 0, 0));
        stim_rows.push_back(make_row(fqs_pkg::KIND_SEARCH, 32'h5555_aaaa, 1, 1,
                                     fqs_pkg::STAT_NOT_FOUND, 0, 0, 0));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[n]) begin
            row = stim_rows[n];
            for (r = 0; r < row.reps; r++) begin
                send_request(row.kind, row.value + 32'(r), row.typed, row.want);
            end
        end

        // Runs of mostly enqueues and mostly dequeues drive the queue between
        // empty and full, so the head wraps and both refusals recur.
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (model_count >= DEPTH && $urandom_range(0, 99) < 30) begin
                filling = 1'b0;
            end else if (model_count == 0 && $urandom_range(0, 99) < 30) begin
                filling = 1'b1;
            end
            roll = int'($urandom_range(0, 99));
            if (roll < 3) begin
                kind = fqs_pkg::KIND_NOP;
            end else if (roll < 28) begin
                kind = fqs_pkg::KIND_SEARCH;
            end else if (roll < 83) begin
                kind = filling ? fqs_pkg::KIND_ENQUEUE : fqs_pkg::KIND_DEQUEUE;
            end else begin
                kind = filling ? fqs_pkg::KIND_DEQUEUE : fqs_pkg::KIND_ENQUEUE;
            end
            if (kind == fqs_pkg::KIND_SEARCH && model_count > 0
                    && $urandom_range(0, 99) < 60) begin
                value = model_mem[slot(model_head
                                       + int'($urandom_range(0, model_count - 1)))];
            end else begin
                value = pick_value();
            end
            send_request(kind, value, 1'b0, none);
        end
        start <= 1'b0;

        while (results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DEPTH + 4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
